// ===== rtl/qsd_pkg.sv =====
`timescale 1ns / 1ps
// qsd_pkg: widths, constants and helper functions of the 16-QAM soft demapper
// used by qam16_soft_demapper; depends on nothing
package qsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NOISE_BITS  = 16;
    localparam int LLR_MAX     = 120;
    localparam int LLR_BITS    = 8;
    localparam int LANES       = 4;

    // lane order of the four soft bits
    localparam int LN_FIRST_RE  = 0;
    localparam int LN_FIRST_IM  = 1;
    localparam int LN_SECOND_RE = 2;
    localparam int LN_SECOND_IM = 3;

    localparam int FRAC_X     = SAMPLE_BITS - 3;
    localparam int FRAC_V     = NOISE_BITS - 4;
    localparam int GAIN_Q     = 24;
    localparam int GAIN_W     = 26;
    localparam int UNIT_SHIFT = GAIN_Q + FRAC_X;
    localparam int DEN_SHIFT  = UNIT_SHIFT - FRAC_V;

    localparam int T_W    = SAMPLE_BITS + GAIN_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int SQ5_W  = SQ_W + 3;
    localparam int L5_W   = T_W + 4;
    localparam int PROD_W = L5_W + 8;
    localparam int V100_W = NOISE_BITS + 7;
    localparam int DEN_W  = V100_W + 1;
    localparam int NUM_W  = NOISE_BITS + 15;
    localparam int QB     = LLR_BITS - 1;
    localparam int VLD_N  = 5 + QB + 1;

    // 4/sqrt(10) in q.24
    localparam logic signed [GAIN_W-1:0] GAIN_C = 26'sd21221686;
    localparam logic [7:0] SCL2 = 8'(2 * LLR_MAX);

    typedef logic signed [T_W-1:0]      t_gain;
    typedef logic signed [L5_W-1:0]     t_l5;
    typedef logic [L5_W-1:0]            t_mag;
    typedef logic [NUM_W-1:0]           t_num;
    typedef logic [V100_W-1:0]          t_v100;
    typedef logic [DEN_W-1:0]           t_den;
    typedef logic [QB-1:0]              t_q;
    typedef logic signed [LLR_BITS-1:0] t_llr;

    localparam t_l5 FOUR_FIFTHS = L5_W'(4) <<< UNIT_SHIFT;

    // bits 0 and 1, five times the soft value
    function automatic t_l5 outer_l5(input t_gain t, input logic far);
        t_l5 te;
        te = L5_W'(t);
        if (far) begin
            outer_l5 = (te <<< 3) + (te <<< 1)
                       - (te[L5_W-1] ? -FOUR_FIFTHS : FOUR_FIFTHS);
        end else begin
            outer_l5 = (te <<< 2) + te;
        end
    endfunction

    // bits 2 and 3, five times the soft value
    function automatic t_l5 inner_l5(input t_gain t);
        t_l5 te;
        t_l5 ta;
        te = L5_W'(t);
        ta = te[L5_W-1] ? -te : te;
        inner_l5 = FOUR_FIFTHS - ((ta <<< 2) + ta);
    endfunction

endpackage

// ===== rtl/qam16_soft_demapper.sv =====
`timescale 1ns / 1ps
// qam16_soft_demapper: 16-QAM max-log soft demapper, four soft bits per symbol
// depends on qsd_pkg
// throughput: one word per cycle; busy stays low, the pipeline never stalls
// the quotient by the noise variance comes from a 7-stage restoring divider
// reset: synchronous active low, clears the valid bits; words in flight are dropped
module qam16_soft_demapper
    import qsd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_symbol_real,
    input  logic signed [SAMPLE_BITS-1:0] i_symbol_imag,
    input  logic [NOISE_BITS-1:0]         i_noise_variance,
    output logic                          o_strobe,
    output logic signed [LLR_BITS-1:0]    o_llr_first_real,
    output logic signed [LLR_BITS-1:0]    o_llr_first_imag,
    output logic signed [LLR_BITS-1:0]    o_llr_second_real,
    output logic signed [LLR_BITS-1:0]    o_llr_second_imag
);

    logic [VLD_N-1:0] r_vld;

    // stage 1: gain and square products
    t_gain                  r1_t_re, r1_t_im;
    logic [SQ_W-1:0]        r1_sq_re, r1_sq_im;
    logic [NOISE_BITS-1:0]  r1_v;
    logic signed [SQ_W-1:0] n1_sq_re, n1_sq_im;

    // stage 2: scaled soft values
    t_l5   r2_l5 [LANES];
    t_v100 r2_v100;
    logic  r2_zero;
    logic  n2_far_re, n2_far_im;

    // stage 3: magnitude and sign
    t_mag  r3_mag [LANES];
    logic  r3_neg [LANES];
    t_v100 r3_v100;
    logic  r3_zero;

    // stage 4: saturation test and rescaled numerator
    t_num  r4_scaled [LANES];
    logic  r4_sat [LANES];
    logic  r4_neg [LANES];
    t_v100 r4_v100;
    logic  r4_zero;

    // divider stages
    t_num r_rem [QB+1][LANES];
    t_q   r_q   [QB+1][LANES];
    logic r_dsat [QB+1][LANES];
    logic r_dneg [QB+1][LANES];
    t_den r_dden [QB+1];
    logic r_dzero [QB+1];
    t_num n_rem [QB][LANES];
    t_q   n_q   [QB][LANES];

    // output stage
    t_llr r_llr [LANES];
    t_llr n_llr [LANES];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VLD_N-2:0], start & ~busy};
        end
    end

    assign n1_sq_re = i_symbol_real * i_symbol_real;
    assign n1_sq_im = i_symbol_imag * i_symbol_imag;

    always_ff @(posedge i_clk) begin
        r1_t_re  <= i_symbol_real * GAIN_C;
        r1_t_im  <= i_symbol_imag * GAIN_C;
        r1_sq_re <= n1_sq_re;
        r1_sq_im <= n1_sq_im;
        r1_v     <= i_noise_variance;
    end

    assign n2_far_re = (SQ5_W'(r1_sq_re) * SQ5_W'(5)) > (SQ5_W'(1) << (2 * FRAC_X + 1));
    assign n2_far_im = (SQ5_W'(r1_sq_im) * SQ5_W'(5)) > (SQ5_W'(1) << (2 * FRAC_X + 1));

    always_ff @(posedge i_clk) begin
        r2_l5[LN_FIRST_RE]  <= outer_l5(r1_t_re, n2_far_re);
        r2_l5[LN_FIRST_IM]  <= outer_l5(r1_t_im, n2_far_im);
        r2_l5[LN_SECOND_RE] <= inner_l5(r1_t_re);
        r2_l5[LN_SECOND_IM] <= inner_l5(r1_t_im);
        r2_v100             <= V100_W'(r1_v) * V100_W'(100);
        r2_zero             <= (r1_v == '0);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r3_neg[k] <= r2_l5[k][L5_W-1];
            r3_mag[k] <= r2_l5[k][L5_W-1] ? t_mag'(-r2_l5[k]) : t_mag'(r2_l5[k]);
        end
        r3_v100 <= r2_v100;
        r3_zero <= r2_zero;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r4_scaled[k] <= NUM_W'((PROD_W'(r3_mag[k]) * PROD_W'(SCL2)) >> DEN_SHIFT);
            r4_sat[k]    <= (r3_mag[k] >> DEN_SHIFT) >= L5_W'(r3_v100);
            r4_neg[k]    <= r3_neg[k];
        end
        r4_v100 <= r3_v100;
        r4_zero <= r3_zero;
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < QB; j++) begin
            for (int k = 0; k < LANES; k++) begin
                if (r_rem[j][k] >= (NUM_W'(r_dden[j]) << (QB - 1 - j))) begin
                    n_rem[j][k] = r_rem[j][k] - (NUM_W'(r_dden[j]) << (QB - 1 - j));
                    n_q[j][k]   = r_q[j][k] | (t_q'(1) << (QB - 1 - j));
                end else begin
                    n_rem[j][k] = r_rem[j][k];
                    n_q[j][k]   = r_q[j][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r_rem[0][k]  <= r4_scaled[k] + NUM_W'(r4_v100);
            r_q[0][k]    <= '0;
            r_dsat[0][k] <= r4_sat[k];
            r_dneg[0][k] <= r4_neg[k];
        end
        r_dden[0]  <= {r4_v100, 1'b0};
        r_dzero[0] <= r4_zero;
        for (int j = 0; j < QB; j++) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[j+1][k]  <= n_rem[j][k];
                r_q[j+1][k]    <= n_q[j][k];
                r_dsat[j+1][k] <= r_dsat[j][k];
                r_dneg[j+1][k] <= r_dneg[j][k];
            end
            r_dden[j+1]  <= r_dden[j];
            r_dzero[j+1] <= r_dzero[j];
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (r_dzero[QB]) begin
                n_llr[k] = '0;
            end else if (r_dsat[QB][k]) begin
                n_llr[k] = r_dneg[QB][k] ? -t_llr'(LLR_MAX) : t_llr'(LLR_MAX);
            end else begin
                n_llr[k] = r_dneg[QB][k] ? -t_llr'({1'b0, r_q[QB][k]})
                                         : t_llr'({1'b0, r_q[QB][k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r_llr[k] <= n_llr[k];
        end
    end

    assign o_strobe          = r_vld[VLD_N-1];
    assign o_llr_first_real  = r_llr[LN_FIRST_RE];
    assign o_llr_first_imag  = r_llr[LN_FIRST_IM];
    assign o_llr_second_real = r_llr[LN_SECOND_RE];
    assign o_llr_second_imag = r_llr[LN_SECOND_IM];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for qam16_soft_demapper, with a clocked driver and monitor
// and a bit-exact integer model of the max-log soft bits; depends on qsd_pkg and the rtl

module tb_top;
    import qsd_pkg::*;

    localparam int           HALF_PERIOD  = 6;
    localparam int           RESET_CYCLES = 12;
    localparam int           RANDOM_ITEMS = 650;
    localparam int           PIPE_DEPTH   = 13;
    localparam int           WDOG_LIMIT   = 2000;
    localparam int           MAX_REPORTS  = 10;
    localparam longint       SQRT_GAIN    = 64'sd21221686;
    localparam longint       FOUR_FIFTHS  = 64'sd4 <<< UNIT_SHIFT;
    localparam longint       FAR_LIMIT    = 64'sd2 <<< (2 * FRAC_X);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [NOISE_BITS-1:0]         nv;
        int                            gap;
        bit                            drain;
    } t_symbol_item;

    typedef struct {
        t_llr first_re;
        t_llr first_im;
        t_llr second_re;
        t_llr second_im;
    } t_soft_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_symbol_real = '0;
    logic signed [SAMPLE_BITS-1:0] i_symbol_imag = '0;
    logic [NOISE_BITS-1:0]         i_noise_variance = '0;
    logic                          o_strobe;
    logic signed [LLR_BITS-1:0]    o_llr_first_real;
    logic signed [LLR_BITS-1:0]    o_llr_first_imag;
    logic signed [LLR_BITS-1:0]    o_llr_second_real;
    logic signed [LLR_BITS-1:0]    o_llr_second_imag;

    t_symbol_item symbol_q[$];
    t_soft_word   soft_q[$];
    t_symbol_item drv_item;
    t_soft_word   got_word;
    t_soft_word   want_word;
    logic         taken = 1'b0;
    int           gap_left = 0;
    int           idle_cycles = 0;
    int           words_in = 0;
    int           words_out = 0;
    int           mism_cnt = 0;
    int           stray_cnt = 0;
    int           zero_var_cnt = 0;
    int           sat_lanes = 0;

    qam16_soft_demapper u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_symbol_real     (i_symbol_real),
        .i_symbol_imag     (i_symbol_imag),
        .i_noise_variance  (i_noise_variance),
        .o_strobe          (o_strobe),
        .o_llr_first_real  (o_llr_first_real),
        .o_llr_first_imag  (o_llr_first_imag),
        .o_llr_second_real (o_llr_second_real),
        .o_llr_second_imag (o_llr_second_imag)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // five times the soft value of bits 0 and 1, in units of 2^-UNIT_SHIFT
    function automatic longint outer_soft5(input longint s);
        longint t;
        longint mag;
        t = SQRT_GAIN * s;
        mag = (s < 0) ? -s : s;
        if (5 * mag * mag > FAR_LIMIT) begin
            return 10 * t - ((s < 0) ? -FOUR_FIFTHS : FOUR_FIFTHS);
        end
        return 5 * t;
    endfunction

    // five times the soft value of bits 2 and 3
    function automatic longint inner_soft5(input longint s);
        longint mag;
        mag = (s < 0) ? -s : s;
        return FOUR_FIFTHS - 5 * (SQRT_GAIN * mag);
    endfunction

    // divide by variance, clip, scale to llr range, round half away from zero
    function automatic t_llr scale_soft(input longint l5, input longint unsigned v);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        if (l5 == 0) begin
            return '0;
        end
        mag = (l5 < 0) ? -l5 : l5;
        num = mag * longint'(LLR_MAX);
        den = (longint'(100) * v) << (UNIT_SHIFT - FRAC_V);
        if (num >= longint'(LLR_MAX) * den) begin
            q = longint'(LLR_MAX);
        end else begin
            q = (2 * num + den) / (2 * den);
        end
        return (l5 < 0) ? t_llr'(-q) : t_llr'(q);
    endfunction

    function automatic t_soft_word demap_symbol(input logic signed [SAMPLE_BITS-1:0] re,
                                                input logic signed [SAMPLE_BITS-1:0] im,
                                                input logic [NOISE_BITS-1:0] nv);
        t_soft_word w;
        longint     sre;
        longint     sim;
        longint unsigned v;
        sre = longint'(re);
        sim = longint'(im);
        v = 64'(nv);
        w = '{default: '0};
        if (v != 0) begin
            w.first_re  = scale_soft(outer_soft5(sre), v);
            w.first_im  = scale_soft(outer_soft5(sim), v);
            w.second_re = scale_soft(inner_soft5(sre), v);
            w.second_im = scale_soft(inner_soft5(sim), v);
        end
        return w;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 8))
                    0: s = 16'h8000;
                    1: s = 16'h7fff;
                    2: s = 16'h0000;
                    3: s = 16'hffff;
                    4: s = 16'h0001;
                    5: s = 16'd5181;
                    6: s = 16'd5182;
                    7: s = -16'sd5181;
                    default: s = -16'sd5182;
                endcase
            end
            1: begin
                s = SAMPLE_BITS'(16'd5181 + $urandom_range(0, 8) - 4);
                if ($urandom_range(0, 1)) begin
                    s = -s;
                end
            end
            default: s = SAMPLE_BITS'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [NOISE_BITS-1:0] pick_variance();
        logic [NOISE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = NOISE_BITS'($urandom_range(1, 64));
            2: v = NOISE_BITS'(16'hffff - $urandom_range(0, 3));
            3, 4, 5: v = NOISE_BITS'($urandom_range(1024, 16384));
            default: v = NOISE_BITS'($urandom);
        endcase
        return v;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_symbol(input logic [SAMPLE_BITS-1:0] re,
                                input logic [SAMPLE_BITS-1:0] im,
                                input logic [NOISE_BITS-1:0] nv, input int gap, input bit drain);
        t_symbol_item it;
        it.re = re;
        it.im = im;
        it.nv = nv;
        it.gap = gap;
        it.drain = drain;
        symbol_q.push_back(it);
    endtask

    // driver: words change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !taken) begin
                // hold the word until accepted
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
                i_symbol_real <= SAMPLE_BITS'($urandom);
                i_symbol_imag <= SAMPLE_BITS'($urandom);
                i_noise_variance <= NOISE_BITS'($urandom);
            end else if (symbol_q.size() != 0 && !(symbol_q[0].drain && soft_q.size() != 0)) begin
                drv_item = symbol_q.pop_front();
                start <= 1'b1;
                i_symbol_real <= drv_item.re;
                i_symbol_imag <= drv_item.im;
                i_noise_variance <= drv_item.nv;
                gap_left <= drv_item.gap;
            end else begin
                start <= 1'b0;
                i_symbol_real <= SAMPLE_BITS'($urandom);
                i_symbol_imag <= SAMPLE_BITS'($urandom);
                i_noise_variance <= NOISE_BITS'($urandom);
            end
        end
    end

    // monitor: acceptance and results on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            taken <= start && busy === 1'b0;
            if (start && busy === 1'b0) begin
                want_word = demap_symbol(i_symbol_real, i_symbol_imag, i_noise_variance);
                soft_q.push_back(want_word);
                words_in <= words_in + 1;
                if (i_noise_variance == 0) begin
                    zero_var_cnt <= zero_var_cnt + 1;
                end
            end
            if (o_strobe !== 1'b0) begin
                if (soft_q.size() == 0) begin
                    stray_cnt <= stray_cnt + 1;
                    if (mism_cnt + stray_cnt < MAX_REPORTS) begin
                        $display("unexpected word %h %h %h %h at %0t", o_llr_first_real,
                                 o_llr_first_imag, o_llr_second_real, o_llr_second_imag,
                                 $realtime);
                    end
                end else begin
                    want_word = soft_q.pop_front();
                    got_word.first_re  = o_llr_first_real;
                    got_word.first_im  = o_llr_first_imag;
                    got_word.second_re = o_llr_second_real;
                    got_word.second_im = o_llr_second_imag;
                    sat_lanes <= sat_lanes
                        + ((want_word.first_re == LLR_MAX
                            || want_word.first_re == -LLR_MAX) ? 1 : 0)
                        + ((want_word.first_im == LLR_MAX
                            || want_word.first_im == -LLR_MAX) ? 1 : 0)
                        + ((want_word.second_re == LLR_MAX
                            || want_word.second_re == -LLR_MAX) ? 1 : 0)
                        + ((want_word.second_im == LLR_MAX
                            || want_word.second_im == -LLR_MAX) ? 1 : 0);
                    if (got_word.first_re !== want_word.first_re
                        || got_word.first_im !== want_word.first_im
                        || got_word.second_re !== want_word.second_re
                        || got_word.second_im !== want_word.second_im) begin
                        mism_cnt <= mism_cnt + 1;
                        if (mism_cnt + stray_cnt < MAX_REPORTS) begin
                            $display("word %0d mismatch: expected %0d %0d %0d %0d, %s",
                                     words_out, want_word.first_re, want_word.first_im,
                                     want_word.second_re, want_word.second_im,
                                     $sformatf("got %0d %0d %0d %0d",
                                               got_word.first_re, got_word.first_im,
                                               got_word.second_re, got_word.second_im));
                        end
                    end
                end
                words_out <= words_out + 1;
            end
        end
    end

    // watchdog on cycles with no accepted word in either direction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && busy === 1'b0) || o_strobe !== 1'b0) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        bit burst;
        // corners: extremes, threshold edges, zero and tiny variance
        queue_symbol(16'h0000, 16'h0000, 16'd4096, 0, 1'b0);
        queue_symbol(16'h7fff, 16'h8000, 16'd4096, 0, 1'b0);
        queue_symbol(16'h8000, 16'h7fff, 16'hffff, 0, 1'b0);
        queue_symbol(16'd5181, -16'sd5181, 16'd4096, 0, 1'b0);
        queue_symbol(16'd5182, -16'sd5182, 16'd4096, 1, 1'b0);
        queue_symbol(16'd5181, 16'd5182, 16'd1, 0, 1'b0);
        queue_symbol(16'hffff, 16'h0001, 16'd4096, 0, 1'b0);
        queue_symbol(16'h0001, 16'hffff, 16'hffff, 0, 1'b0);
        queue_symbol(16'd1000, -16'sd3000, 16'd0, 0, 1'b0);
        queue_symbol(16'h7fff, 16'h7fff, 16'd0, 2, 1'b0);
        queue_symbol(16'h8000, 16'h8000, 16'd1, 0, 1'b0);
        queue_symbol(16'd8192, -16'sd8192, 16'd4096, 0, 1'b0);
        queue_symbol(16'd16384, -16'sd16384, 16'd2048, 0, 1'b0);
        queue_symbol(16'd2590, -16'sd2591, 16'd8192, 0, 1'b0);
        queue_symbol(16'h0000, 16'h0000, 16'hffff, 0, 1'b0);
        queue_symbol(16'd12000, -16'sd20000, 16'd300, 0, 1'b0);
        queue_symbol(-16'sd7777, 16'd7777, 16'd40000, 0, 1'b0);
        queue_symbol(16'h7fff, 16'h8000, 16'hffff, 0, 1'b0);
        queue_symbol(16'h5555, 16'haaaa, 16'h5555, 0, 1'b0);
        queue_symbol(16'haaaa, 16'h5555, 16'haaaa, 0, 1'b0);
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            queue_symbol(pick_sample(), pick_sample(), pick_variance(), pick_gap(burst),
                         n == 0 || $urandom_range(0, 99) == 0);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (symbol_q.size() != 0 || start) @(posedge i_clk);
        @(negedge i_clk);
        while (soft_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);

        $display("%0d symbols sent, %0d soft words checked", words_in, words_out);
        $display("%0d with zero variance, %0d saturated lanes", zero_var_cnt, sat_lanes);
        if (mism_cnt == 0 && stray_cnt == 0 && soft_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d unexpected words", mism_cnt, stray_cnt);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qsd_pkg.sv
rtl/qam16_soft_demapper.sv
dv/tb_top.sv
